### hdl/b64d_pkg.sv
// constants, error codes and the alphabet lookup for the base64 stream decoder
`default_nettype none

package b64d_pkg;

  localparam int unsigned CODE_W  = 7;
  localparam int unsigned ERR_W   = 3;
  localparam int unsigned SLOTS   = 3;

  typedef logic [CODE_W-1:0] code_t;
  typedef logic [ERR_W-1:0]  err_t;
  typedef logic [7:0]        byte_t;
  typedef logic [1:0]        cnt_t;

  localparam code_t SEXTET_MASK  = 7'h3F;
  localparam code_t CODE_INVALID = 7'd127;
  localparam code_t CODE_PAD     = 7'd64;

  localparam byte_t PAD_CHAR   = 8'd61;
  localparam byte_t CHAR_LF    = 8'd10;
  localparam byte_t CHAR_CR    = 8'd13;
  localparam byte_t CHAR_SPACE = 8'd32;
  localparam byte_t CHAR_PLUS  = 8'd43;
  localparam byte_t CHAR_SLASH = 8'd47;

  localparam err_t ERR_NONE      = 3'd0;
  localparam err_t ERR_SPACE     = 3'd1;
  localparam err_t ERR_PADS      = 3'd2;
  localparam err_t ERR_INVALID   = 3'd3;
  localparam err_t ERR_AFTER_PAD = 3'd4;

  // standard alphabet: sextet value, pad code or invalid code
  function automatic code_t char_code(input byte_t c);
    code_t r;
    r = CODE_INVALID;
    if (c >= 8'd65 && c <= 8'd90) begin
      r = code_t'(c - 8'd65);
    end else if (c >= 8'd97 && c <= 8'd122) begin
      r = code_t'(c - 8'd71);
    end else if (c >= 8'd48 && c <= 8'd57) begin
      r = code_t'(c + 8'd4);
    end else if (c == CHAR_PLUS) begin
      r = 7'd62;
    end else if (c == CHAR_SLASH) begin
      r = 7'd63;
    end else if (c == PAD_CHAR) begin
      r = CODE_PAD;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

### hdl/base64_stream_decoder_top.sv
// base64 stream decoder: one character in, up to three decoded bytes out
//
// channel  handshake            payload
// input    in_valid / in_stall  in_char, final_char
// output   out_valid/out_stall  out_byte, byte_valid, run_last, message_done, error_kind
//
// a character is registered, decoded against the stored quartet state and its
// results moved into a three-slot result register once that register is free
// the output port drains one result per cycle while out_stall is low, so a character
// completing a quartet holds the result register until its one to three bytes leave
// characters causing no result pass the decode stage without waiting on it
// rst is synchronous; it clears the decoder state and empties both stages
// out_stall holds the current result and, once a character with results waits, in_stall
`default_nettype none

module base64_stream_decoder_top (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire b64d_pkg::byte_t    in_char,
  input  wire logic               final_char,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output b64d_pkg::byte_t         out_byte,
  output logic                    byte_valid,
  output logic                    run_last,
  output logic                    message_done,
  output b64d_pkg::err_t          error_kind
);
  import b64d_pkg::*;

  // decoder state
  logic [23:0] sextet_accum, sextet_accum_next;
  logic [1:0]  quartet_pos, quartet_pos_next;
  logic [1:0]  pad_count, pad_count_next;
  logic        spaces_pending, spaces_pending_next;
  logic        cr_pending, cr_pending_next;
  err_t        latched_error, latched_error_next;

  // input register
  logic  a_valid;
  byte_t a_char;
  logic  a_fin;

  // result register
  logic  b_valid;
  cnt_t  b_cnt;
  cnt_t  b_idx;
  byte_t b_bytes [SLOTS];
  logic  b_bvalid;
  logic  b_fin;
  err_t  b_err;

  // decode results
  cnt_t  d_n;
  byte_t d_bytes [SLOTS];
  logic  d_bvalid;

  logic        accept, a_move, out_take, b_last, b_free;
  code_t       code;
  logic [23:0] accum_shift;
  logic [1:0]  pad_inc;
  logic [1:0]  pad_sat;

  assign code        = char_code(a_char);
  assign accum_shift = {sextet_accum[17:0], code[5:0] & SEXTET_MASK[5:0]};
  assign pad_inc     = (code == CODE_PAD) ? 2'(pad_count + 2'd1) : pad_count;
  assign pad_sat     = (pad_inc > 2'd2) ? 2'd2 : pad_inc;

  always_comb begin
    sextet_accum_next   = sextet_accum;
    quartet_pos_next    = quartet_pos;
    pad_count_next      = pad_count;
    spaces_pending_next = spaces_pending;
    cr_pending_next     = cr_pending;
    latched_error_next  = latched_error;
    d_n                 = 2'd0;
    d_bvalid            = 1'b1;
    d_bytes[0]          = accum_shift[23:16];
    d_bytes[1]          = accum_shift[15:8];
    d_bytes[2]          = accum_shift[7:0];
    if (latched_error == ERR_NONE) begin
      if (cr_pending) begin
        if (a_char == CHAR_LF) begin
          cr_pending_next     = 1'b0;
          spaces_pending_next = 1'b0;
        end else begin
          latched_error_next = spaces_pending ? ERR_SPACE : ERR_INVALID;
        end
      end else if (a_char == CHAR_SPACE) begin
        spaces_pending_next = 1'b1;
      end else if (a_char == CHAR_LF) begin
        spaces_pending_next = 1'b0;
      end else if (a_char == CHAR_CR) begin
        if (a_fin) begin
          latched_error_next = spaces_pending ? ERR_SPACE : ERR_INVALID;
        end else begin
          cr_pending_next = 1'b1;
        end
      end else if (spaces_pending) begin
        latched_error_next = ERR_SPACE;
      end else if (a_char == PAD_CHAR && pad_count >= 2'd2) begin
        latched_error_next = ERR_PADS;
      end else if (code == CODE_INVALID) begin
        latched_error_next = ERR_INVALID;
      end else if (code != CODE_PAD && pad_count != 2'd0) begin
        latched_error_next = ERR_AFTER_PAD;
      end else begin
        pad_count_next    = pad_inc;
        sextet_accum_next = accum_shift;
        if (quartet_pos == 2'd3) begin
          quartet_pos_next = 2'd0;
          d_n              = 2'(2'd3 - pad_sat);
        end else begin
          quartet_pos_next = 2'(quartet_pos + 2'd1);
        end
      end
    end
    if (a_fin && d_n == 2'd0) begin
      d_n        = 2'd1;
      d_bvalid   = 1'b0;
      d_bytes[0] = 8'd0;
    end
    if (a_fin) begin
      sextet_accum_next   = 24'd0;
      quartet_pos_next    = 2'd0;
      pad_count_next      = 2'd0;
      spaces_pending_next = 1'b0;
      cr_pending_next     = 1'b0;
    end
  end

  // latched error is carried into the result register before the message resets
  assign out_take = b_valid && !out_stall;
  assign b_last   = (b_idx == 2'(b_cnt - 2'd1));
  assign b_free   = !b_valid || (out_take && b_last);
  assign a_move   = a_valid && (d_n == 2'd0 || b_free);
  assign in_stall = a_valid && !a_move;
  assign accept   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (accept) begin
      a_valid <= 1'b1;
    end else if (a_move) begin
      a_valid <= 1'b0;
    end
    if (accept) begin
      a_char <= in_char;
      a_fin  <= final_char;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sextet_accum   <= 24'd0;
      quartet_pos    <= 2'd0;
      pad_count      <= 2'd0;
      spaces_pending <= 1'b0;
      cr_pending     <= 1'b0;
      latched_error  <= ERR_NONE;
    end else if (a_move) begin
      sextet_accum   <= sextet_accum_next;
      quartet_pos    <= quartet_pos_next;
      pad_count      <= pad_count_next;
      spaces_pending <= spaces_pending_next;
      cr_pending     <= cr_pending_next;
      latched_error  <= a_fin ? ERR_NONE : latched_error_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
      b_idx   <= 2'd0;
    end else if (a_move && d_n != 2'd0) begin
      b_valid <= 1'b1;
      b_idx   <= 2'd0;
    end else if (out_take) begin
      if (b_last) begin
        b_valid <= 1'b0;
      end else begin
        b_idx <= 2'(b_idx + 2'd1);
      end
    end
    if (a_move && d_n != 2'd0) begin
      b_cnt    <= d_n;
      b_bytes  <= d_bytes;
      b_bvalid <= d_bvalid;
      b_fin    <= a_fin;
      b_err    <= latched_error_next;
    end
  end

  assign out_valid    = b_valid;
  assign out_byte     = b_bytes[b_idx];
  assign byte_valid   = b_bvalid;
  assign run_last     = b_last;
  assign message_done = b_fin && b_last;
  assign error_kind   = b_err;

endmodule

`default_nettype wire
